/* sv/pulse_beat_detector_defines.svh */
// Assertion helpers used by the detector sequencer.
`ifndef PULSE_BEAT_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_DETECTOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse beat detector check failed");

// Check that cons holds in the cycle after ante.
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse beat detector check failed");

`endif

/* sv/pbd_pkg.sv */
package pbd_pkg;

    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 20;
    localparam int THR_W      = 19;
    localparam int RATE_W     = 16;
    localparam int STATE_W    = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 19;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 6;

    localparam int unsigned SAMPLE_STEP_MS = 10;
    localparam int unsigned FALLOFF_Q15    = 22938;
    localparam logic [15:0] Q15_ONE        = 16'h8000;
    localparam logic [15:0] RATE_NUM       = 16'd60000;

    localparam logic [18:0] RST_MIN_THR   = 19'd20;
    localparam logic [18:0] RST_MAX_THR   = 19'd800;
    localparam logic [15:0] RST_STEP      = 16'd30;
    localparam logic [15:0] RST_INIT_HOLD = 16'd2000;
    localparam logic [15:0] RST_MASK_HOLD = 16'd200;
    localparam logic [15:0] RST_INVALID   = 16'd2000;
    localparam logic [14:0] RST_DECAY     = 15'd32440;
    localparam logic [15:0] RST_ALPHA     = 16'd19661;

    typedef enum logic [STATE_W-1:0] {
        MD_INIT  = 3'd0,
        MD_WAIT  = 3'd1,
        MD_SLOPE = 3'd2,
        MD_MAYBE = 3'd3,
        MD_MASK  = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_THR   = 4'd0,
        CFG_MAX_THR   = 4'd1,
        CFG_STEP      = 4'd2,
        CFG_INIT_HOLD = 4'd3,
        CFG_MASK_HOLD = 4'd4,
        CFG_INVALID   = 4'd5,
        CFG_DECAY     = 4'd6,
        CFG_ALPHA     = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EVAL,
        CS_PREP,
        CS_FALL,
        CS_RATE,
        CS_PUSH
    } t_ctl_state;

    typedef struct packed {
        logic [TIME_W-1:0]          time_ms;
        logic signed [SAMPLE_W-1:0] pulse_sample;
    } t_in_item;

    typedef struct packed {
        logic                 beat_found;
        logic [RATE_W-1:0]    rate_bpm;
        logic [THR_W-1:0]     current_threshold;
        logic [STATE_W-1:0]   detector_state;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_fall;
        logic div_rate;
        logic fin_fall;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic fall_pend;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/pbd_div.sv */
module pbd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pbd_pkg::DIV_W-1:0]      i_dividend,
    input  logic [pbd_pkg::DIV_W-1:0]      i_divisor,
    input  logic [pbd_pkg::DIV_CNT_W-1:0]  i_nbits,
    output logic                           o_done,
    output logic [pbd_pkg::DIV_W-1:0]      o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [pbd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [pbd_pkg::DIV_W-1:0]     r_rem;
    logic [pbd_pkg::DIV_W-1:0]     r_quo;
    logic [pbd_pkg::DIV_W-1:0]     r_dvs;
    logic [pbd_pkg::DIV_W:0]       trial;
    logic                          qbit;
    logic [pbd_pkg::DIV_W-1:0]     n_rem;

    // one restoring step per cycle, most significant dividend bit first
    always_comb begin
        trial = {r_rem, r_quo[pbd_pkg::DIV_W-1]};
        qbit  = (trial >= {1'b0, r_dvs});
        n_rem = qbit ? pbd_pkg::DIV_W'(trial - {1'b0, r_dvs})
                     : trial[pbd_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pbd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend << (pbd_pkg::DIV_CNT_W'(pbd_pkg::DIV_W) - i_nbits);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[pbd_pkg::DIV_W-2:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/pbd_datapath.sv */
module pbd_datapath #(
    parameter int unsigned SAMPLE_STEP_MS = pbd_pkg::SAMPLE_STEP_MS,
    parameter int unsigned FALLOFF_Q15    = pbd_pkg::FALLOFF_Q15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pbd_pkg::t_in_item                 i_in_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output pbd_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  pbd_pkg::t_dp_cmd                  i_cmd,
    output pbd_pkg::t_dp_status               o_status
);

    localparam int TW = pbd_pkg::THR_W;
    // reciprocal for the samples-per-beat division, exact for any 32-bit period
    localparam int          SPB_SH    = 32 + $clog2(SAMPLE_STEP_MS);
    localparam logic [32:0] SPB_RECIP =
        33'(((65'd1 << SPB_SH) / 65'(SAMPLE_STEP_MS)) + 65'd1);

    logic [TW-1:0] r_min_thr, r_max_thr;
    logic [15:0]   r_step, r_init_hold, r_mask_hold, r_invalid, r_alpha;
    logic [14:0]   r_decay;

    logic [pbd_pkg::TIME_W-1:0]          r_time;
    logic signed [pbd_pkg::SAMPLE_W-1:0] r_s;
    pbd_pkg::t_mode                      r_mode, n_mode;
    logic [TW-1:0]                       r_peak, n_peak;
    logic [31:0]                         r_period, n_period;
    logic signed [pbd_pkg::SAMPLE_W-1:0] r_lp, n_lp;
    logic [31:0]                         r_lbt, n_lbt;
    logic                                r_beat, n_beat;
    logic                                r_fall_pend, n_fall_pend;
    logic                                r_out_valid;
    pbd_pkg::t_out_item                  r_out_data;

    logic [31:0]          elapsed;
    logic signed [TW+1:0] s_ext, peak_ext, max_ext;
    logic [TW-1:0]        clip_s;
    logic [15:0]          alpha_c;
    logic [47:0]          cur_term, hist_term;
    logic [33:0]          fall_prod;
    logic [TW-1:0]        fall_val;
    logic [64:0]          spb_prod;
    logic [31:0]          spb_q;

    logic                          div_start, div_done;
    logic [pbd_pkg::DIV_W-1:0]     div_dividend, div_divisor, div_q, spb;
    logic [pbd_pkg::DIV_CNT_W-1:0] div_nbits;
    logic signed [TW+1:0]          fall_diff;

    assign elapsed  = r_time - r_lbt;
    assign s_ext    = (TW+2)'(r_s);
    assign peak_ext = $signed({2'b00, r_peak});
    assign max_ext  = $signed({2'b00, r_max_thr});
    assign clip_s   = (s_ext < max_ext) ? r_s[TW-1:0] : r_max_thr;
    assign alpha_c  = (r_alpha > pbd_pkg::Q15_ONE) ? pbd_pkg::Q15_ONE : r_alpha;
    assign cur_term  = 48'(alpha_c) * 48'(elapsed);
    assign hist_term = 48'(pbd_pkg::Q15_ONE - alpha_c) * 48'(r_period);
    assign fall_prod = 34'(FALLOFF_Q15) * 34'(r_lp[TW-1:0]);
    assign fall_val  = fall_prod[33:15];

    // detector step, all but the falloff division
    always_comb begin
        logic        do_decay;
        logic [33:0] dec_prod;
        logic signed [TW+2:0] drop_ext;
        do_decay    = 1'b0;
        dec_prod    = '0;
        drop_ext    = (TW+3)'(r_s) + $signed({3'b000, r_step});
        n_mode      = r_mode;
        n_peak      = r_peak;
        n_period    = r_period;
        n_lp        = r_lp;
        n_lbt       = r_lbt;
        n_beat      = 1'b0;
        n_fall_pend = 1'b0;
        case (r_mode)
            pbd_pkg::MD_INIT: begin
                if (r_time > {16'b0, r_init_hold}) n_mode = pbd_pkg::MD_WAIT;
            end
            pbd_pkg::MD_WAIT: begin
                if (s_ext > peak_ext) begin
                    n_peak = clip_s;
                    n_mode = pbd_pkg::MD_SLOPE;
                end
                if (elapsed > {16'b0, r_invalid}) begin
                    n_period = '0;
                    n_lp     = '0;
                end
                do_decay = 1'b1;
            end
            pbd_pkg::MD_SLOPE: begin
                if (s_ext < peak_ext) n_mode = pbd_pkg::MD_MAYBE;
                else n_peak = clip_s;
            end
            pbd_pkg::MD_MAYBE: begin
                if (drop_ext < $signed({3'b000, r_peak})) begin
                    n_beat = 1'b1;
                    n_lp   = r_s;
                    n_mode = pbd_pkg::MD_MASK;
                    if (elapsed != '0) n_period = cur_term[46:15] + hist_term[46:15];
                    n_lbt = r_time;
                end else begin
                    n_mode = pbd_pkg::MD_SLOPE;
                end
            end
            pbd_pkg::MD_MASK: begin
                if (elapsed > {16'b0, r_mask_hold}) n_mode = pbd_pkg::MD_WAIT;
                do_decay = 1'b1;
            end
            default: begin
                n_mode   = pbd_pkg::MD_INIT;
                n_peak   = r_min_thr;
                n_period = '0;
                n_lp     = '0;
                n_lbt    = '0;
            end
        endcase
        if (do_decay) begin
            if (n_lp > 0 && n_period != '0) begin
                n_fall_pend = 1'b1;
            end else begin
                dec_prod = 34'(r_decay) * 34'(n_peak);
                if (n_peak != '0) n_peak = dec_prod[33:15];
                if (n_peak < r_min_thr) n_peak = r_min_thr;
            end
        end
    end

    // samples per beat by reciprocal multiplication, at least one
    assign spb_prod = 65'(r_period) * 65'(SPB_RECIP);
    assign spb_q    = 32'(spb_prod >> SPB_SH);
    assign spb      = (spb_q == '0) ? pbd_pkg::DIV_W'(1) : spb_q;

    // shared divider: falloff share when one is pending, then rate
    always_comb begin
        div_dividend = pbd_pkg::DIV_W'(pbd_pkg::RATE_NUM);
        div_divisor  = r_period;
        div_nbits    = pbd_pkg::DIV_CNT_W'(pbd_pkg::RATE_W);
        if (i_cmd.div_fall) begin
            div_dividend = pbd_pkg::DIV_W'(fall_val);
            div_divisor  = spb;
            div_nbits    = pbd_pkg::DIV_CNT_W'(TW);
        end
    end

    assign div_start = i_cmd.div_fall | i_cmd.div_rate;
    assign fall_diff = peak_ext - $signed({2'b00, div_q[TW-1:0]});

    pbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_nbits    (div_nbits),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_thr   <= pbd_pkg::RST_MIN_THR;
            r_max_thr   <= pbd_pkg::RST_MAX_THR;
            r_step      <= pbd_pkg::RST_STEP;
            r_init_hold <= pbd_pkg::RST_INIT_HOLD;
            r_mask_hold <= pbd_pkg::RST_MASK_HOLD;
            r_invalid   <= pbd_pkg::RST_INVALID;
            r_decay     <= pbd_pkg::RST_DECAY;
            r_alpha     <= pbd_pkg::RST_ALPHA;
        end else if (i_cfg_we) begin
            case (pbd_pkg::t_cfg_idx'(i_cfg_index))
                pbd_pkg::CFG_MIN_THR:   r_min_thr   <= i_cfg_data;
                pbd_pkg::CFG_MAX_THR:   r_max_thr   <= i_cfg_data;
                pbd_pkg::CFG_STEP:      r_step      <= i_cfg_data[15:0];
                pbd_pkg::CFG_INIT_HOLD: r_init_hold <= i_cfg_data[15:0];
                pbd_pkg::CFG_MASK_HOLD: r_mask_hold <= i_cfg_data[15:0];
                pbd_pkg::CFG_INVALID:   r_invalid   <= i_cfg_data[15:0];
                pbd_pkg::CFG_DECAY:     r_decay     <= i_cfg_data[14:0];
                pbd_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pbd_pkg::MD_INIT;
            r_peak      <= pbd_pkg::RST_MIN_THR;
            r_period    <= '0;
            r_lp        <= '0;
            r_lbt       <= '0;
            r_beat      <= 1'b0;
            r_fall_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_mode      <= n_mode;
                r_peak      <= n_peak;
                r_period    <= n_period;
                r_lp        <= n_lp;
                r_lbt       <= n_lbt;
                r_beat      <= n_beat;
                r_fall_pend <= n_fall_pend;
            end
            if (i_cmd.fin_fall) begin
                r_peak <= (fall_diff < $signed({2'b00, r_min_thr})) ? r_min_thr
                                                                     : fall_diff[TW-1:0];
            end
            if (i_cmd.push) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time <= i_in_data.time_ms;
            r_s    <= i_in_data.pulse_sample;
        end
        if (i_cmd.push) begin
            r_out_data.beat_found        <= r_beat;
            r_out_data.rate_bpm          <= (r_period == '0) ? '0 : div_q[pbd_pkg::RATE_W-1:0];
            r_out_data.current_threshold <= r_peak;
            r_out_data.detector_state    <= r_mode;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;
    assign o_status.fall_pend = r_fall_pend;
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

endmodule

/* sv/pbd_ctrl.sv */
`include "pulse_beat_detector_defines.svh"

module pbd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pbd_pkg::t_dp_status  i_status,
    output pbd_pkg::t_dp_cmd     o_cmd
);

    pbd_pkg::t_ctl_state r_state, n_state;
    logic                in_accept;
    logic                in_div;

    assign in_accept = i_in_valid && !o_in_stall;
    assign in_div    = (r_state == pbd_pkg::CS_FALL) || (r_state == pbd_pkg::CS_RATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pbd_pkg::CS_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbd_pkg::CS_IDLE: if (i_in_valid) n_state = pbd_pkg::CS_EVAL;
            pbd_pkg::CS_EVAL: n_state = pbd_pkg::CS_PREP;
            pbd_pkg::CS_PREP: begin
                n_state = i_status.fall_pend ? pbd_pkg::CS_FALL : pbd_pkg::CS_RATE;
            end
            pbd_pkg::CS_FALL: if (i_status.div_done) n_state = pbd_pkg::CS_RATE;
            pbd_pkg::CS_RATE: if (i_status.div_done) n_state = pbd_pkg::CS_PUSH;
            pbd_pkg::CS_PUSH: if (i_status.out_free) n_state = pbd_pkg::CS_IDLE;
            default: n_state = pbd_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            pbd_pkg::CS_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            pbd_pkg::CS_EVAL: o_cmd.eval = 1'b1;
            pbd_pkg::CS_PREP: begin
                o_cmd.div_fall = i_status.fall_pend;
                o_cmd.div_rate = !i_status.fall_pend;
            end
            pbd_pkg::CS_FALL: begin
                o_cmd.fin_fall = i_status.div_done;
                o_cmd.div_rate = i_status.div_done;
            end
            pbd_pkg::CS_RATE: ;
            pbd_pkg::CS_PUSH: o_cmd.push = i_status.out_free;
            default: ;
        endcase
    end

    `PBD_ASSERT_NEXT(a_accept_evals, i_clk, i_rst_n, in_accept, r_state == pbd_pkg::CS_EVAL)
    `PBD_ASSERT_SAME(a_one_div_start, i_clk, i_rst_n, 1'b1, !(o_cmd.div_fall && o_cmd.div_rate))
    `PBD_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, i_status.div_done, in_div)

endmodule

/* sv/pulse_beat_detector.sv */
// Sequence: load the sample, evaluate the step, then run the divider for the rate;
//   a falloff pass comes first when the threshold decays by the period-based falloff.
// A new sample is taken only once the last result is in the output register, which
//   an output stall delays; the shared bit-serial divider retires one quotient bit per cycle.
// Reset: synchronous, active low; restores register defaults, init state,
//   threshold at the minimum, period and last beat cleared, no result pending.
module pulse_beat_detector #(
    parameter int unsigned SAMPLE_STEP_MS = pbd_pkg::SAMPLE_STEP_MS,
    parameter int unsigned FALLOFF_Q15    = pbd_pkg::FALLOFF_Q15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pbd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pbd_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // command and status between sequencer and datapath
    pbd_pkg::t_dp_cmd    cmd;
    pbd_pkg::t_dp_status status;

    // register writes are always taken; indexes past the list are dropped
    assign o_cfg_ready = 1'b1;

    // sequencer: evaluate the step, run the divider passes, then transfer
    // the result into the output register once it is free
    pbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: detector state, registers, divider and output register
    pbd_datapath #(
        .SAMPLE_STEP_MS (SAMPLE_STEP_MS),
        .FALLOFF_Q15    (FALLOFF_Q15)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
